### rtl/core/msic_pkg.sv
`default_nettype none
package msic_pkg;
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic [5:0]         position;
        logic [8:0]         comparisons;
        logic [10:0]        inversions;
        logic               overflow;
        logic               last_out;
    } t_out_item;

    localparam logic [8:0]  CMP_MAX = 9'd511;
    localparam logic [10:0] INV_MAX = 11'd2047;

    typedef enum logic [3:0] {
        S_COLLECT,
        S_PASS,
        S_COPY,
        S_MREQ,
        S_MWAIT,
        S_MSTEP,
        S_EREQ,
        S_EWAIT,
        S_EOUT
    } t_state;
endpackage
`default_nettype wire

### rtl/core/merge_sort_inversion_counter.sv
`default_nettype none
// Merge sort with inversion count.
// Input channel (i_valid/o_ready, payload t_in_item): one signed element per
// transaction; the transaction with last set closes the array. Up to
// MAX_ELEMENTS are stored; extras are dropped and overflow is flagged.
// After last, the block sorts ascending with a stable merge sort that walks
// the top-down midpoint split tree in post-order with a small range stack,
// so compare and inversion counts match a recursive merge sort exactly.
// Each merge step reads two heads from RAM0 (synchronous, registered read)
// and writes one element to RAM1; the merged range is then copied back to
// RAM0, each element read from RAM1 and then written.
// Output channel (o_valid/i_ready, payload t_out_item): n transactions in
// sorted order, each read from RAM0 before it is offered and each carrying
// both totals; last_out marks the final one.
// A stall on the output holds the current result; no input is taken while
// sorting or emitting. Reset clears counters and returns to collection; the
// element stores need no clearing.
module merge_sort_inversion_counter
    import msic_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int VALUE_WIDTH  = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);
    localparam int AW  = $clog2(MAX_ELEMENTS);
    localparam int CW  = AW + 1;
    localparam int SPW = $clog2(2 * AW + 3);  // stack holds up to 2*AW+1 ranges

    t_state r_state, n_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic [8:0]    r_cmp;
    logic [10:0]   r_inv;
    logic          r_side;    // which RAM holds the current runs
    logic [0:0]    r_level;   // copy phase: read, then write back
    logic [CW-1:0] r_node;    // node index, declared but not used
    logic [CW-1:0] r_lo, r_mid, r_hi, r_i, r_j, r_k;
    logic [CW-1:0] r_pos;

    // Walk the split tree in post-order with an explicit stack of ranges:
    // descend pushes right then left, a leaf is dropped, and a node whose
    // children are done is merged and popped.
    logic [CW-1:0] r_stk_lo [1 << SPW];
    logic [CW-1:0] r_stk_hi [1 << SPW];
    logic          r_stk_dn [1 << SPW];
    logic [SPW-1:0] r_sp;

    logic          we0, we1;
    logic [AW-1:0] waddr, ra, rb;
    logic [VALUE_WIDTH-1:0] wdata, q0a, q0b, q1a, q1b, qa, qb;

    msic_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(1 << AW)) u_ram0 (
        .i_clk, .i_we(we0), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .o_rdata_a(q0a), .i_raddr_b(rb), .o_rdata_b(q0b)
    );
    msic_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(1 << AW)) u_ram1 (
        .i_clk, .i_we(we1), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr_a(ra), .o_rdata_a(q1a), .i_raddr_b(rb), .o_rdata_b(q1b)
    );

    // Merge source is always RAM r_side, destination the other; after each
    // merge the range is copied back (S_COPY) so the store stays single-homed.
    assign qa = r_side ? q1a : q0a;
    assign qb = r_side ? q1b : q0b;

    logic in_acc, out_acc, take_a, left_ok, right_ok;
    logic [CW-1:0] mid_c;
    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign left_ok  = r_i <= r_mid;
    assign right_ok = r_j <= r_hi;
    assign take_a   = left_ok && (!right_ok || $signed(qa) <= $signed(qb));

    logic [SPW-1:0] sp_m1;
    assign sp_m1 = r_sp - 1'b1;
    logic [CW-1:0] top_lo, top_hi;
    assign top_lo = r_stk_lo[sp_m1];
    assign top_hi = r_stk_hi[sp_m1];
    assign mid_c  = top_lo + ((top_hi - top_lo) >> 1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_COLLECT: if (in_acc && i_data.last) begin
                n_state = S_PASS;
            end
            S_PASS: begin
                if (r_sp == '0) begin
                    n_state = (r_count == '0) ? S_COLLECT : S_EREQ;
                end else if (top_lo < top_hi && r_stk_dn[sp_m1]) begin
                    n_state = S_MREQ;
                end
            end
            S_MREQ:  n_state = S_MWAIT;
            S_MWAIT: n_state = S_MSTEP;
            S_MSTEP: n_state = (r_k == r_hi) ? S_COPY : S_MREQ;
            S_COPY:  n_state = (r_k == r_hi && r_level[0]) ? S_PASS : S_COPY;
            S_EREQ:  n_state = S_EWAIT;
            S_EWAIT: n_state = S_EOUT;
            S_EOUT: if (i_ready) begin
                n_state = (r_pos + 1'b1 == r_count) ? S_COLLECT : S_EREQ;
            end
            default: n_state = S_COLLECT;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        o_ready = (r_state == S_COLLECT);
        o_valid = (r_state == S_EOUT);
        we0 = 1'b0;
        we1 = 1'b0;
        waddr = r_count[AW-1:0];
        wdata = VALUE_WIDTH'(i_data.value);
        ra = r_i[AW-1:0];
        rb = r_j[AW-1:0];
        unique case (r_state)
            S_COLLECT: we0 = in_acc && (r_count < CW'(MAX_ELEMENTS));
            S_MSTEP: begin
                waddr = r_k[AW-1:0];
                wdata = take_a ? qa : qb;
                we1 = 1'b1;
            end
            S_COPY: begin
                // read dest at k in level-0 phase, write src in level-1 phase
                ra = r_k[AW-1:0];
                waddr = r_k[AW-1:0];
                wdata = q1a;
                we0 = r_level[0];
            end
            S_EREQ, S_EWAIT, S_EOUT: ra = r_pos[AW-1:0];
            default: ;
        endcase
        o_data.sorted_value = 32'($signed(q0a));
        o_data.position     = 6'(r_pos);
        o_data.comparisons  = r_cmp;
        o_data.inversions   = r_inv;
        o_data.overflow     = r_ovf;
        o_data.last_out     = (r_pos + 1'b1 == r_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_cmp   <= '0;
            r_inv   <= '0;
            r_sp    <= '0;
            r_pos   <= '0;
            r_level <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_COLLECT: if (in_acc) begin
                    if (r_count < CW'(MAX_ELEMENTS)) begin
                        r_count <= r_count + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_cmp <= '0;
                    r_inv <= '0;
                    r_pos <= '0;
                    if (i_data.last) begin
                        // push root range
                        r_stk_lo[0] <= '0;
                        r_stk_hi[0] <= (r_count < CW'(MAX_ELEMENTS)) ? r_count : r_count - 1'b1;
                        r_stk_dn[0] <= 1'b0;
                        r_sp <= SPW'(1);
                    end
                end
                S_PASS: if (r_sp != '0) begin
                    if (top_lo >= top_hi) begin
                        r_sp <= sp_m1;  // leaf: drop
                    end else if (!r_stk_dn[sp_m1]) begin
                        // descend: mark, push right then left (left on top)
                        r_stk_dn[sp_m1] <= 1'b1;
                        r_stk_lo[r_sp] <= mid_c + 1'b1;
                        r_stk_hi[r_sp] <= top_hi;
                        r_stk_dn[r_sp] <= 1'b0;
                        r_stk_lo[r_sp + 1'b1] <= top_lo;
                        r_stk_hi[r_sp + 1'b1] <= mid_c;
                        r_stk_dn[r_sp + 1'b1] <= 1'b0;
                        r_sp <= r_sp + 2'd2;
                    end else begin
                        // children done: merge and pop
                        r_lo <= top_lo; r_mid <= mid_c; r_hi <= top_hi;
                        r_i <= top_lo; r_j <= mid_c + 1'b1; r_k <= top_lo;
                        r_sp <= sp_m1;
                        r_level <= '0;
                    end
                end
                S_MSTEP: begin
                    if (left_ok && right_ok) begin
                        if (r_cmp != CMP_MAX) r_cmp <= r_cmp + 1'b1;
                        if (!take_a) begin
                            r_inv <= ({1'b0, r_inv} + 12'(r_mid + 1'b1 - r_i) > {1'b0, INV_MAX})
                                   ? INV_MAX : r_inv + 11'(r_mid + 1'b1 - r_i);
                        end
                    end
                    if (take_a) r_i <= r_i + 1'b1; else r_j <= r_j + 1'b1;
                    if (r_k == r_hi) begin
                        r_k <= r_lo;
                        r_level <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_COPY: begin
                    // alternate: issue read at k, then write it back at k
                    r_level <= r_level ^ 1'b1;
                    if (r_level[0] && r_k != r_hi) r_k <= r_k + 1'b1;
                end
                S_EOUT: if (i_ready) begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos + 1'b1 == r_count) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign r_side = 1'b0;

    // Copy write uses the RAM1 word registered by the preceding read phase.
    a_no_in_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COLLECT) |-> !o_ready)
        else $error("input taken while sorting");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count beyond capacity");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(r_pos)))
        else $error("result dropped under stall");
endmodule
`default_nettype wire

### rtl/core/msic_ram.sv
`default_nettype none
module msic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire
